[rtl/core/pbft_pkg.sv]
// ----------------------------------------------------------------------------
// pbft_pkg: shared types and constants of the protobuf field tokenizer
// Holds the buffer capacity, derived widths, parse phases, wire type codes
// and the request structs of the input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package pbft_pkg;

    // Largest buffer the tokenizer accepts, in bytes.
    localparam int MAX_BUFFER_BYTES = 4096;

    // Width of a byte index that can also hold MAX_BUFFER_BYTES itself.
    localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 1);

    // Longest varint, in bytes, and the last legal shift step.
    localparam int VARINT_MAX_BYTES = 10;
    localparam logic [3:0] VARINT_LAST_STEP = 4'(VARINT_MAX_BYTES - 1);

    // Fixed body sizes.
    localparam logic [3:0] FIXED64_BYTES = 4'd8;
    localparam logic [3:0] FIXED32_BYTES = 4'd4;

    // Wire type codes.
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_VARVAL,
        PH_LENVAR,
        PH_FIXED,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] field_value;
        logic [11:0] data_offset;
        logic [12:0] data_length;
        logic        malformed;
        logic        buffer_end;
    } out_t;

endpackage

`default_nettype wire

[rtl/core/pbft_varint.sv]
// ----------------------------------------------------------------------------
// pbft_varint: one step of varint accumulation
// Merges the low seven bits of a byte into the accumulator at the current
// step and flags the final byte and an overlong varint.
// ----------------------------------------------------------------------------
`default_nettype none

module pbft_varint (
    input  wire logic [63:0] accum,
    input  wire logic [3:0]  step,
    input  wire logic [7:0]  data_byte,
    output logic      [63:0] accum_next,
    output logic      [3:0]  step_next,
    output logic             done,
    output logic             overlong
);

    logic [6:0] bit_shift;

    // step * 7; bits that land above bit 63 are simply lost.
    assign bit_shift = {step, 3'b000} - {3'b000, step};

    always_comb begin
        accum_next = accum;
        if (bit_shift < 7'd64) begin
            accum_next = accum | (64'(data_byte[6:0]) << bit_shift[5:0]);
        end
        done      = !data_byte[7];
        overlong  = data_byte[7] && (step >= pbft_pkg::VARINT_LAST_STEP);
        step_next = step + 4'd1;
    end

endmodule

`default_nettype wire

[rtl/core/pbft_parser.sv]
// ----------------------------------------------------------------------------
// pbft_parser: field parse state and per-byte decode
// Holds the parse state and turns each accepted byte into at most one
// field or error record.
// ----------------------------------------------------------------------------
`default_nettype none

module pbft_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire pbft_pkg::in_t  in_data,
    output logic                res_valid,
    output pbft_pkg::out_t      res_data
);

    localparam int PW = pbft_pkg::POS_W;
    localparam logic [PW-1:0] MAX_POS = PW'(pbft_pkg::MAX_BUFFER_BYTES);

    pbft_pkg::phase_t phase_reg, phase_next;
    logic [63:0]      accum_reg, accum_next;
    logic [3:0]       shift_reg, shift_next;
    logic [31:0]      number_reg, number_next;
    logic [2:0]       wire_reg, wire_next;
    logic [PW-1:0]    remain_reg, remain_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [PW-1:0]    start_reg, start_next;
    logic             drop_reg, drop_next;

    logic [63:0] vi_accum;
    logic [3:0]  vi_step;
    logic        vi_done;
    logic        vi_overlong;

    pbft_varint u_varint (
        .accum      (accum_reg),
        .step       (shift_reg),
        .data_byte  (in_data.data_byte),
        .accum_next (vi_accum),
        .step_next  (vi_step),
        .done       (vi_done),
        .overlong   (vi_overlong)
    );

    logic [PW-1:0] idx_inc;
    logic [PW-1:0] room;
    logic [PW-1:0] remain_dec;
    logic [PW-1:0] fixed_len;
    logic [63:0]   fixed_accum;
    logic [31:0]   tag_number;
    logic [2:0]    tag_wire;
    logic          last;
    logic          do_emit;
    logic          bad;
    logic          fell_through;

    assign last       = in_data.last_byte;
    assign idx_inc    = pos_reg + PW'(1);
    assign room       = MAX_POS - idx_inc;
    assign remain_dec = (remain_reg != '0) ? remain_reg - PW'(1) : remain_reg;
    assign tag_number = vi_accum[34:3];
    assign tag_wire   = vi_accum[2:0];
    assign fixed_len  = (vi_accum[2:0] == pbft_pkg::WT_FIXED64) ?
                        PW'(pbft_pkg::FIXED64_BYTES) : PW'(pbft_pkg::FIXED32_BYTES);

    always_comb begin
        fixed_accum = accum_reg;
        if (shift_reg < 4'd8) begin
            fixed_accum = accum_reg | (64'(in_data.data_byte) << {shift_reg[2:0], 3'b000});
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        shift_next   = shift_reg;
        number_next  = number_reg;
        wire_next    = wire_reg;
        remain_next  = remain_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        drop_next    = drop_reg;
        do_emit      = 1'b0;
        bad          = 1'b0;
        fell_through = 1'b0;
        res_data     = '0;

        if (accept) begin
            if (drop_reg) begin
                if (last) begin
                    phase_next  = pbft_pkg::PH_TAG;
                    accum_next  = '0;
                    shift_next  = '0;
                    remain_next = '0;
                    pos_next    = '0;
                    drop_next   = 1'b0;
                end
            end else if (pos_reg >= MAX_POS) begin
                do_emit = 1'b1;
                bad     = 1'b1;
            end else begin
                pos_next = idx_inc;
                unique case (phase_reg)
                    pbft_pkg::PH_TAG: begin
                        accum_next = vi_accum;
                        shift_next = vi_step;
                        if (vi_overlong) begin
                            do_emit = 1'b1;
                            bad     = 1'b1;
                        end else if (vi_done) begin
                            number_next = tag_number;
                            wire_next   = tag_wire;
                            accum_next  = '0;
                            shift_next  = '0;
                            start_next  = idx_inc;
                            if (tag_number == '0 || last) begin
                                do_emit = 1'b1;
                                bad     = 1'b1;
                            end else if (tag_wire == pbft_pkg::WT_VARINT) begin
                                phase_next = pbft_pkg::PH_VARVAL;
                            end else if (tag_wire == pbft_pkg::WT_LEN) begin
                                phase_next = pbft_pkg::PH_LENVAR;
                            end else if (tag_wire == pbft_pkg::WT_FIXED64 ||
                                         tag_wire == pbft_pkg::WT_FIXED32) begin
                                if (room < fixed_len) begin
                                    do_emit = 1'b1;
                                    bad     = 1'b1;
                                end else begin
                                    remain_next = fixed_len;
                                    phase_next  = pbft_pkg::PH_FIXED;
                                end
                            end else begin
                                do_emit = 1'b1;
                                bad     = 1'b1;
                            end
                        end else begin
                            fell_through = 1'b1;
                        end
                    end
                    pbft_pkg::PH_VARVAL: begin
                        accum_next = vi_accum;
                        shift_next = vi_step;
                        if (vi_overlong) begin
                            do_emit = 1'b1;
                            bad     = 1'b1;
                        end else if (vi_done) begin
                            do_emit                = 1'b1;
                            res_data.field_number  = number_reg;
                            res_data.wire_type     = pbft_pkg::WT_VARINT;
                            res_data.field_value   = vi_accum;
                            res_data.data_offset   = 12'(start_reg);
                        end else begin
                            fell_through = 1'b1;
                        end
                    end
                    pbft_pkg::PH_LENVAR: begin
                        accum_next = vi_accum;
                        shift_next = vi_step;
                        if (vi_overlong) begin
                            do_emit = 1'b1;
                            bad     = 1'b1;
                        end else if (vi_done) begin
                            if (vi_accum > 64'(room)) begin
                                do_emit = 1'b1;
                                bad     = 1'b1;
                            end else if (vi_accum == '0) begin
                                do_emit               = 1'b1;
                                res_data.field_number = number_reg;
                                res_data.wire_type    = pbft_pkg::WT_LEN;
                                res_data.data_offset  = 12'(idx_inc);
                            end else if (last) begin
                                do_emit = 1'b1;
                                bad     = 1'b1;
                            end else begin
                                remain_next = vi_accum[PW-1:0];
                                start_next  = idx_inc;
                                phase_next  = pbft_pkg::PH_BODY;
                            end
                        end else begin
                            fell_through = 1'b1;
                        end
                    end
                    pbft_pkg::PH_FIXED: begin
                        accum_next  = fixed_accum;
                        shift_next  = shift_reg + 4'd1;
                        remain_next = remain_dec;
                        if (remain_dec == '0) begin
                            do_emit               = 1'b1;
                            res_data.field_number = number_reg;
                            res_data.wire_type    = wire_reg;
                            res_data.field_value  = fixed_accum;
                            res_data.data_offset  = 12'(start_reg);
                            res_data.data_length  = (wire_reg == pbft_pkg::WT_FIXED64) ?
                                13'(pbft_pkg::FIXED64_BYTES) : 13'(pbft_pkg::FIXED32_BYTES);
                        end else begin
                            fell_through = 1'b1;
                        end
                    end
                    pbft_pkg::PH_BODY: begin
                        remain_next = remain_dec;
                        if (remain_dec == '0) begin
                            do_emit               = 1'b1;
                            res_data.field_number = number_reg;
                            res_data.wire_type    = pbft_pkg::WT_LEN;
                            res_data.data_offset  = 12'(start_reg);
                            res_data.data_length  = 13'(idx_inc - start_reg);
                        end else begin
                            fell_through = 1'b1;
                        end
                    end
                    default: begin
                        do_emit = 1'b1;
                        bad     = 1'b1;
                    end
                endcase

                // A field still open on the last byte is a truncated buffer.
                if (fell_through && last) begin
                    do_emit = 1'b1;
                    bad     = 1'b1;
                end
            end

            if (do_emit) begin
                if (bad) begin
                    res_data.field_number = '0;
                    res_data.wire_type    = '0;
                    res_data.field_value  = '0;
                    res_data.data_offset  = '0;
                    res_data.data_length  = '0;
                end
                res_data.malformed  = bad;
                res_data.buffer_end = last;
                phase_next  = pbft_pkg::PH_TAG;
                accum_next  = '0;
                shift_next  = '0;
                remain_next = '0;
                if (last) begin
                    pos_next  = '0;
                    drop_next = 1'b0;
                end else begin
                    drop_next = bad;
                end
            end
        end

        res_valid = do_emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= pbft_pkg::PH_TAG;
            accum_reg  <= '0;
            shift_reg  <= '0;
            number_reg <= '0;
            wire_reg   <= '0;
            remain_reg <= '0;
            pos_reg    <= '0;
            start_reg  <= '0;
            drop_reg   <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            shift_reg  <= shift_next;
            number_reg <= number_next;
            wire_reg   <= wire_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            drop_reg   <= drop_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pbft_out_buf.sv]
// ----------------------------------------------------------------------------
// pbft_out_buf: result register with skid stage
// Holds finished records until the consumer takes them, with one spare
// entry so that the input side keeps flowing while the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pbft_out_buf (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire pbft_pkg::out_t  push_data,
    output logic                 has_room,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output pbft_pkg::out_t       m_data
);

    logic           main_valid_reg, main_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    pbft_pkg::out_t main_data_reg, main_data_next;
    pbft_pkg::out_t skid_data_reg, skid_data_next;

    assign has_room = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end else begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

[rtl/core/protobuf_field_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// protobuf_field_tokenizer_core: streaming protobuf wire-format tokenizer
// Takes an encoded buffer one byte per request and returns one record for
// each completed field, or one error record for a malformed buffer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Request contents
//   s_        in         one buffer byte and a flag on the buffer's last byte
//   m_        out        field number, wire type, value, offset, length, flags
//
// A byte is decoded in the cycle it is accepted, and its record, if any, is
// in the result buffer on the next cycle, so the core takes one byte per
// cycle. The parse state registers and a two-entry result buffer set that
// figure; it holds unless both result entries are full, when s_ready drops.
// Reset is synchronous and active low; it returns the parser to awaiting a
// tag at buffer offset zero and empties the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module protobuf_field_tokenizer_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire pbft_pkg::in_t   s_payload,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output pbft_pkg::out_t       m_payload
);

    logic           accept;
    logic           res_valid;
    pbft_pkg::out_t res_data;
    logic           has_room;

    // A byte may enter whenever a spare result entry exists, since each
    // byte yields at most one record.
    assign s_ready = has_room;
    assign accept  = s_valid && has_room;

    pbft_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_data   (s_payload),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    pbft_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res_data),
        .has_room  (has_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_payload)
    );

endmodule

`default_nettype wire
